/* rtl/core/slt_pkg.sv */
// Shared types and codes for the sequential list table.
package slt_pkg;

	localparam int KIND_W  = 2;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 7;
	localparam int STAT_W  = 2;
	localparam int FOUND_W = 6;
	localparam int COUNT_W = 7;

	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL_OR_BAD = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 2'd2;

	typedef struct packed {
		logic              load_in;
		logic              start_scan;
		logic              start_shup;
		logic              start_shdn;
		logic              flush;
		logic              shift_wr;
		logic              wr_key;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              set_found;
		logic              load_res;
		logic [STAT_W-1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              cnt_zero;
		logic              full;
		logic              pos_bad;
		logic              pos_at_end;
		logic              match;
		logic              match_last;
		logic              busy;
		logic              out_free;
	} sts_t;

endpackage

/* rtl/core/slt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/slt_dp.sv */
// Datapath: operand latches, entry count, scan and shift pointers, result register.
module slt_dp import slt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic [KIND_W-1:0]                                in_kind,
	input  logic [KEY_W-1:0]                                 in_key,
	input  logic [POS_W-1:0]                                 in_pos,
	input  cmd_t                                             cmd,
	output sts_t                                             sts,
	output logic                                             ram_we,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_waddr,
	output logic [KEY_W-1:0]                                 ram_wdata,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_raddr,
	input  logic [KEY_W-1:0]                                 ram_rdata,
	output logic [$clog2(CAPACITY + 1)-1:0]                  cnt,
	output logic                                             out_valid,
	input  logic                                             out_ready,
	output logic [STAT_W-1:0]                                out_status,
	output logic [FOUND_W-1:0]                               out_found,
	output logic [COUNT_W-1:0]                               out_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > POS_W) ? CW : POS_W;
	localparam logic [MW-1:0] CAP_M = MW'(CAPACITY);

	logic [KIND_W-1:0]  kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [POS_W-1:0]   pos_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      rd_idx_q;
	logic [AW-1:0]      end_q;
	logic               up_q;
	logic               iss_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	logic [FOUND_W-1:0] found_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [FOUND_W-1:0] out_found_q;
	logic [COUNT_W-1:0] out_count_q;

	logic [MW-1:0] cnt_m;
	logic [MW-1:0] pos_m;
	logic [MW-1:0] idx_m;
	logic [CW-1:0] cnt_less1;
	logic [AW-1:0] cnt_last;
	logic [CW-1:0] idx_next_c;
	logic          out_free;

	assign cnt_m      = MW'(cnt_q);
	assign pos_m      = MW'(pos_q);
	assign idx_m      = MW'(idx_s1);
	assign cnt_less1  = cnt_q - CW'(1);
	assign cnt_last   = cnt_less1[AW-1:0];
	assign idx_next_c = CW'(idx_s1) + CW'(1);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		sts.kind       = kind_q;
		sts.cnt_zero   = (cnt_q == '0);
		sts.full       = (cnt_m >= CAP_M);
		sts.pos_bad    = (pos_m > cnt_m);
		sts.pos_at_end = (pos_m == cnt_m);
		sts.match      = vld_s1 && (ram_rdata == key_q);
		sts.match_last = (idx_next_c == cnt_q);
		sts.busy       = iss_q || vld_s1;
		sts.out_free   = out_free;
	end

	assign ram_raddr = rd_idx_q;
	assign ram_we    = cmd.wr_key || (cmd.shift_wr && vld_s1);
	assign ram_waddr = cmd.wr_key ? pos_m[AW-1:0]
		: (up_q ? (idx_s1 - AW'(1)) : (idx_s1 + AW'(1)));
	assign ram_wdata = cmd.wr_key ? key_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_less1;
			end
			if (cmd.start_scan || cmd.start_shup || cmd.start_shdn) begin
				iss_q  <= 1'b1;
				vld_s1 <= 1'b0;
			end else if (cmd.flush) begin
				iss_q  <= 1'b0;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= iss_q;
				if (iss_q && (rd_idx_q == end_q)) begin
					iss_q <= 1'b0;
				end
			end
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_kind;
			key_q  <= in_key;
			pos_q  <= in_pos;
		end
		if (cmd.start_scan) begin
			rd_idx_q <= '0;
			end_q    <= cnt_last;
			up_q     <= 1'b1;
		end else if (cmd.start_shup) begin
			rd_idx_q <= cnt_last;
			end_q    <= pos_m[AW-1:0];
			up_q     <= 1'b0;
		end else if (cmd.start_shdn) begin
			rd_idx_q <= idx_s1 + AW'(1);
			end_q    <= cnt_last;
			up_q     <= 1'b1;
		end else if (iss_q && (rd_idx_q != end_q)) begin
			rd_idx_q <= up_q ? (rd_idx_q + AW'(1)) : (rd_idx_q - AW'(1));
		end
		idx_s1 <= rd_idx_q;
		if (cmd.load_in) begin
			found_q <= '0;
		end else if (cmd.set_found) begin
			found_q <= idx_m[FOUND_W-1:0];
		end
		if (cmd.load_res) begin
			out_status_q <= cmd.res_status;
			out_found_q  <= found_q;
			out_count_q  <= cnt_m[COUNT_W-1:0];
		end
	end

	assign cnt        = cnt_q;
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_found  = out_found_q;
	assign out_count  = out_count_q;

endmodule

/* rtl/core/slt_ctrl.sv */
// Controller state machine that sequences search, insert and delete requests.
module slt_ctrl import slt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STAT_W-1:0] stat_q;
	logic [STAT_W-1:0] stat_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		stat_d   = stat_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.kind)
					KIND_SEARCH, KIND_DELETE: begin
						if (sts.cnt_zero) begin
							stat_d  = ST_NOT_FOUND;
							state_d = S_RESP;
						end else begin
							cmd.start_scan = 1'b1;
							state_d        = S_SCAN;
						end
					end
					KIND_INSERT: begin
						if (sts.full || sts.pos_bad) begin
							stat_d  = ST_FULL_OR_BAD;
							state_d = S_RESP;
						end else if (sts.pos_at_end) begin
							cmd.wr_key  = 1'b1;
							cmd.cnt_inc = 1'b1;
							stat_d      = ST_OK;
							state_d     = S_RESP;
						end else begin
							cmd.start_shup = 1'b1;
							state_d        = S_SHIFT;
						end
					end
					default: begin
						stat_d  = ST_FULL_OR_BAD;
						state_d = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.match) begin
					stat_d = ST_OK;
					if (sts.kind == KIND_SEARCH) begin
						cmd.set_found = 1'b1;
						cmd.flush     = 1'b1;
						state_d       = S_RESP;
					end else if (sts.match_last) begin
						cmd.cnt_dec = 1'b1;
						cmd.flush   = 1'b1;
						state_d     = S_RESP;
					end else begin
						cmd.start_shdn = 1'b1;
						state_d        = S_SHIFT;
					end
				end else if (!sts.busy) begin
					stat_d  = ST_NOT_FOUND;
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				if (!sts.busy) begin
					stat_d = ST_OK;
					if (sts.kind == KIND_INSERT) begin
						cmd.wr_key  = 1'b1;
						cmd.cnt_inc = 1'b1;
					end else begin
						cmd.cnt_dec = 1'b1;
					end
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				cmd.res_status = stat_q;
				if (sts.out_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

endmodule

/* rtl/core/sequential_list_table.sv */
// Top level of the sequential list table: an ordered list of keys with search,
// insert and delete. One request at a time; the scan and the shift each walk the
// entry RAM one entry per cycle through its single read port.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low) empties the list and clears all handshake state at once.
module sequential_list_table import slt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // key[31:0], position[38:32], zero[39]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], found_position[7:2], count[14:8], zero[15]
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	cmd_t               cmd;
	sts_t               sts;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [KEY_W-1:0]   ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [KEY_W-1:0]   ram_rdata;
	logic [CW-1:0]      cnt;
	logic [STAT_W-1:0]  out_status;
	logic [FOUND_W-1:0] out_found;
	logic [COUNT_W-1:0] out_count;

	slt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	slt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_kind    (s_tuser),
		.in_key     (s_tdata[KEY_W-1:0]),
		.in_pos     (s_tdata[KEY_W+POS_W-1:KEY_W]),
		.cmd        (cmd),
		.sts        (sts),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.cnt        (cnt),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_found  (out_found),
		.out_count  (out_count)
	);

	slt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_tdata = {1'b0, out_count, out_found, out_status};

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("new request taken while one is in progress");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !s_tready)
		else $error("entry store written while idle");

	a_cnt_change_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt) |-> !$past(s_tready))
		else $error("entry count changed without a request in progress");
`endif

endmodule

/* verif/tb_sequential_list_table.sv */
// Self-checking testbench for the sequential list table: directed, fill and random request streams.
`timescale 1ns / 100ps

module tb_sequential_list_table import slt_pkg::*;;

	localparam int CAPACITY       = 64;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_BLOCKS  = 18;
	localparam int BLOCK_SIZE     = 100;

	// The kind encoding that names no operation.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FOUND_W-1:0] found;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	logic [KEY_W-1:0] model_keys [CAPACITY];
	int               model_count = 0;
	list_result_t     results_due [$];
	int               fail_count = 0;
	int               idle_cycles = 0;
	bit               tx_idle_on = 1'b1;
	bit               rx_idle_on = 1'b1;
	bit               hold_request = 1'b0;
	int               hold_left = 0;
	int               rx_stall_left = 0;

	logic [KEY_W-1:0] key_pool [16] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'hFFFF_FFFE,
		32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0010, 32'h1234_5678,
		32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0100, 32'hDEAD_BEEF
	};

	sequential_list_table #(.CAPACITY(CAPACITY)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int find_key(input logic [KEY_W-1:0] key);
		for (int i = 0; i < model_count; i++)
			if (model_keys[i] == key)
				return i;
		return -1;
	endfunction

	function automatic list_result_t predict_list_op(input logic [KIND_W-1:0] kind,
			input logic [KEY_W-1:0] key, input logic [POS_W-1:0] pos);
		list_result_t res;
		int at;
		res.status = ST_FULL_OR_BAD;
		res.found = '0;
		case (kind)
			KIND_SEARCH: begin
				at = find_key(key);
				if (at >= 0) begin
					res.status = ST_OK;
					res.found = at[FOUND_W-1:0];
				end else
					res.status = ST_NOT_FOUND;
			end
			KIND_INSERT: begin
				if (model_count < CAPACITY && int'(pos) <= model_count) begin
					for (int j = model_count; j > int'(pos); j--)
						model_keys[j] = model_keys[j-1];
					model_keys[pos] = key;
					model_count++;
					res.status = ST_OK;
				end
			end
			KIND_DELETE: begin
				at = find_key(key);
				if (at >= 0) begin
					for (int j = at; j + 1 < model_count; j++)
						model_keys[j] = model_keys[j+1];
					model_count--;
					res.status = ST_OK;
				end else
					res.status = ST_NOT_FOUND;
			end
			default: res.status = ST_FULL_OR_BAD;
		endcase
		res.count = model_count[COUNT_W-1:0];
		return res;
	endfunction

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) < 7)
			return key_pool[$urandom_range(0, 15)];
		return $urandom();
	endfunction

	function automatic logic [KEY_W-1:0] pick_stored_key();
		if (model_count == 0)
			return pick_key();
		return model_keys[$urandom_range(0, model_count - 1)];
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return POS_W'($urandom_range(0, model_count));
		if (r < 85)
			return POS_W'(model_count);
		if (r < 90)
			return '0;
		return POS_W'($urandom());
	endfunction

	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = pick_gap(tx_idle_on);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, pos, key};
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		results_due.push_back(predict_list_op(kind, key, pos));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_request(KIND_SEARCH, 32'h0000_0000, 7'd0);
		send_request(KIND_DELETE, 32'h0000_0005, 7'd0);
		send_request(KIND_INSERT, 32'h0000_0007, 7'd1);
		send_request(KIND_INSERT, 32'h0000_0007, 7'h7F);
		send_request(KIND_UNUSED, 32'hFFFF_FFFF, 7'h7F);
		send_request(KIND_INSERT, 32'h8000_0000, 7'd0);
		send_request(KIND_INSERT, 32'h7FFF_FFFF, 7'd1);
		send_request(KIND_INSERT, 32'h0000_0000, 7'd1);
		send_request(KIND_INSERT, 32'hFFFF_FFFF, 7'd0);
		send_request(KIND_INSERT, 32'h7FFF_FFFF, 7'd4);
		send_request(KIND_SEARCH, 32'h7FFF_FFFF, 7'h55);
		send_request(KIND_SEARCH, 32'h8000_0000, 7'd0);
		send_request(KIND_SEARCH, 32'hFFFF_FFFF, 7'd0);
		send_request(KIND_SEARCH, 32'h0001_2345, 7'd0);
		send_request(KIND_INSERT, 32'h0000_0001, 7'd6);
		send_request(KIND_UNUSED, 32'h0000_0000, 7'd0);
		send_request(KIND_DELETE, 32'h7FFF_FFFF, 7'h2A);
		send_request(KIND_SEARCH, 32'h7FFF_FFFF, 7'd0);
		send_request(KIND_DELETE, 32'h5555_5555, 7'd0);
		send_request(KIND_DELETE, 32'hFFFF_FFFF, 7'd0);
		send_request(KIND_DELETE, 32'h8000_0000, 7'd0);
		send_request(KIND_DELETE, 32'h0000_0000, 7'd0);
		send_request(KIND_DELETE, 32'h7FFF_FFFF, 7'd0);
		send_request(KIND_SEARCH, 32'h7FFF_FFFF, 7'd0);
		wait_drained();
	endtask

	// The receiver holds off at the start of the fill, so the block backs up into its input.
	task automatic test_fill_and_empty();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		hold_request = 1'b1;
		while (model_count < CAPACITY)
			send_request(KIND_INSERT, pick_key(), POS_W'($urandom_range(0, model_count)));
		tx_idle_on = 1'b1;
		send_request(KIND_INSERT, 32'h0000_0042, 7'd0);
		send_request(KIND_INSERT, 32'h0000_0042, 7'd64);
		send_request(KIND_INSERT, 32'h0000_0042, 7'd65);
		send_request(KIND_SEARCH, model_keys[CAPACITY-1], 7'd0);
		send_request(KIND_SEARCH, model_keys[0], 7'd0);
		send_request(KIND_UNUSED, 32'h1234_5678, 7'd3);
		while (model_count > 0)
			send_request(KIND_DELETE, pick_stored_key(), POS_W'($urandom()));
		wait_drained();
	endtask

	task automatic test_random_ops();
		int r;
		int insert_weight;
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			insert_weight = (b % 2 == 0) ? 60 : 30;
			for (int n = 0; n < BLOCK_SIZE; n++) begin
				r = $urandom_range(0, 99);
				if (r < insert_weight)
					send_request(KIND_INSERT, pick_key(), pick_position());
				else if (r < insert_weight + 15)
					send_request(KIND_SEARCH,
						($urandom_range(0, 9) < 7) ? pick_stored_key() : pick_key(),
						POS_W'($urandom()));
				else if (r < 96)
					send_request(KIND_DELETE,
						($urandom_range(0, 9) < 7) ? pick_stored_key() : pick_key(),
						POS_W'($urandom()));
				else
					send_request(KIND_UNUSED, $urandom(), POS_W'($urandom()));
			end
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (rx_stall_left > 0) begin
			m_tready <= 1'b0;
			rx_stall_left--;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_stall_left = pick_gap(1'b1);
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[1:0];
			got.found = m_tdata[7:2];
			got.count = m_tdata[14:8];
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result status=%0d found=%0d count=%0d",
					$time, got.status, got.found, got.count);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (got.status != want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
					fail_count++;
				end
				if (got.found != want.found) begin
					$display("%0t: found_position expected %0d actual %0d", $time,
						want.found, got.found);
					fail_count++;
				end
				if (got.count != want.count) begin
					$display("%0t: count expected %0d actual %0d", $time, want.count,
						got.count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("sequential_list_table test failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_empty();
		test_random_ops();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sequential_list_table test passed");
		else
			$display("sequential_list_table test failed");
		$finish;
	end

endmodule
